// ===== rtl/fkr_pkg.sv =====
// Package: shared types and codes for the FIFO with keyed removal.
`timescale 1ns / 1ps
`default_nettype none

package fkr_pkg;

    localparam int KEY_W   = 48;
    localparam int TOTAL_W = 5;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_DEL  = 2'd2,
        OP_PEEK = 2'd3
    } op_t;

    typedef struct packed {
        op_t              func;
        logic [KEY_W-1:0] client_key;
    } in_item_t;

    typedef struct packed {
        logic               ok;
        logic [KEY_W-1:0]   key_out;
        logic               is_empty;
        logic [TOTAL_W-1:0] entry_total;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_HEAD,
        ST_SCAN,
        ST_SHIFT
    } state_t;

    typedef enum logic [1:0] {
        KSRC_ZERO,
        KSRC_RDATA,
        KSRC_HELD
    } key_src_t;

    typedef struct packed {
        logic     load;
        logic     enq_write;
        logic     rd_head;
        logic     rd_next;
        logic     rd_next2;
        logic     idx_inc;
        logic     shift_write;
        logic     hold_head;
        logic     count_inc;
        logic     count_dec;
        logic     report;
        logic     ok;
        key_src_t key_src;
    } dp_cmd_t;

    typedef struct packed {
        op_t  func;
        logic full;
        logic empty;
        logic match;
        logic has_next;
        logic has_next2;
    } dp_status_t;

endpackage : fkr_pkg

`default_nettype wire

// ===== rtl/fifo_with_keyed_removal_top.sv =====
// Top level: bounded key queue with enqueue, dequeue, delete by key and peek.
//
// An item is taken when start is high and busy is low; each item yields exactly
// one result, shown on result for one cycle with done high, and the receiver
// must take it then. Entries live in a single RAM with the head at address 0.
// Busy covers only the decode state on an enqueue, or on a dequeue, peek or
// delete of an empty queue; a peek adds the head state; the dequeue reads the
// head and then moves each later entry up one place per cycle; the delete walks
// the RAM one entry per cycle until the key matches, then moves each later entry
// up one place per cycle through the one read and one write port. done rises in
// the first cycle with busy low, when the next item may already be accepted. No
// clearing pass runs after reset.
`timescale 1ns / 1ps
`default_nettype none

module fifo_with_keyed_removal_top
    import fkr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire in_item_t   request,
    output logic            done,
    output out_item_t       result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    fkr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    fkr_datapath #(
        .DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .status  (status),
        .result  (result),
        .done    (done)
    );

    // An accepted item keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

    // A result only follows a cycle of work
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
    else $error("result without preceding work");

    // A failed operation reports no key
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.ok) |-> (result.key_out == '0))
    else $error("failed operation reported a key");

    // An empty queue reports a zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_empty) |-> (result.entry_total == '0))
    else $error("empty flag disagrees with count");

endmodule : fifo_with_keyed_removal_top

`default_nettype wire

// ===== rtl/fkr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module fkr_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : fkr_ram

`default_nettype wire

// ===== rtl/fkr_ctrl.sv =====
// Controller: sequences enqueue, head read, key scan and gap-closing shift.
`timescale 1ns / 1ps
`default_nettype none

module fkr_ctrl
    import fkr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire dp_status_t status,
    output logic            busy,
    output dp_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.func) inside
                    OP_ENQ:
                    begin
                        state_next = ST_IDLE;
                    end
                    OP_DEQ, OP_PEEK:
                    begin
                        state_next = status.empty ? ST_IDLE : ST_HEAD;
                    end
                    OP_DEL:
                    begin
                        state_next = status.empty ? ST_IDLE : ST_SCAN;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_HEAD:
            begin
                if (status.func == OP_DEQ && status.has_next)
                begin
                    state_next = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (status.match)
                begin
                    state_next = status.has_next ? ST_SHIFT : ST_IDLE;
                end
                else if (!status.has_next)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SHIFT:
            begin
                if (!status.has_next2)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd         = '0;
        cmd.key_src = KSRC_ZERO;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
            end
            ST_DECODE:
            begin
                unique case (status.func) inside
                    OP_ENQ:
                    begin
                        cmd.report = 1'b1;
                        if (!status.full)
                        begin
                            cmd.enq_write = 1'b1;
                            cmd.count_inc = 1'b1;
                            cmd.ok        = 1'b1;
                        end
                    end
                    OP_DEQ, OP_PEEK, OP_DEL:
                    begin
                        if (status.empty)
                        begin
                            cmd.report = 1'b1;
                        end
                        else
                        begin
                            cmd.rd_head = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.report = 1'b1;
                    end
                endcase
            end
            ST_HEAD:
            begin
                cmd.hold_head = 1'b1;
                if (status.func == OP_DEQ && status.has_next)
                begin
                    cmd.rd_next = 1'b1;
                end
                else
                begin
                    cmd.count_dec = (status.func == OP_DEQ);
                    cmd.report    = 1'b1;
                    cmd.ok        = 1'b1;
                    cmd.key_src   = KSRC_RDATA;
                end
            end
            ST_SCAN:
            begin
                if (status.match)
                begin
                    if (status.has_next)
                    begin
                        cmd.rd_next = 1'b1;
                    end
                    else
                    begin
                        cmd.count_dec = 1'b1;
                        cmd.report    = 1'b1;
                        cmd.ok        = 1'b1;
                    end
                end
                else if (status.has_next)
                begin
                    cmd.rd_next = 1'b1;
                    cmd.idx_inc = 1'b1;
                end
                else
                begin
                    cmd.report = 1'b1;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift_write = 1'b1;
                if (status.has_next2)
                begin
                    cmd.rd_next2 = 1'b1;
                    cmd.idx_inc  = 1'b1;
                end
                else
                begin
                    cmd.count_dec = 1'b1;
                    cmd.report    = 1'b1;
                    cmd.ok        = 1'b1;
                    cmd.key_src   = (status.func == OP_DEQ) ? KSRC_HELD : KSRC_ZERO;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule : fkr_ctrl

`default_nettype wire

// ===== rtl/fkr_datapath.sv =====
// Datapath: entry RAM, count, scan index, key compare and result register.
`timescale 1ns / 1ps
`default_nettype none

module fkr_datapath
    import fkr_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire in_item_t   request,
    input  wire dp_cmd_t    cmd,
    output dp_status_t      status,
    output out_item_t       result,
    output logic            done
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [AW-1:0]    idx_reg;
    logic [AW-1:0]    idx_next;
    op_t              func_reg;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] head_reg;
    out_item_t        result_reg;
    out_item_t        result_next;
    logic             done_reg;

    logic [CW:0]      idx_ext;
    logic [CW:0]      count_ext;
    logic             ram_wr_en;
    logic [AW-1:0]    ram_wr_addr;
    logic [KEY_W-1:0] ram_wr_data;
    logic             ram_rd_en;
    logic [AW-1:0]    ram_rd_addr;
    logic [KEY_W-1:0] ram_rd_data;

    assign idx_ext   = (CW + 1)'(idx_reg);
    assign count_ext = (CW + 1)'(count_reg);

    // Select RAM write: append at tail, or move an entry up one place
    always_comb
    begin
        ram_wr_en   = cmd.enq_write || cmd.shift_write;
        ram_wr_addr = cmd.enq_write ? count_reg[AW-1:0] : idx_reg;
        ram_wr_data = cmd.enq_write ? key_reg : ram_rd_data;
    end

    // Select RAM read address: head, next entry, or the one after
    always_comb
    begin
        ram_rd_en   = cmd.rd_head || cmd.rd_next || cmd.rd_next2;
        ram_rd_addr = '0;
        if (cmd.rd_next)
        begin
            ram_rd_addr = AW'(idx_ext + (CW + 1)'(1));
        end
        else if (cmd.rd_next2)
        begin
            ram_rd_addr = AW'(idx_ext + (CW + 1)'(2));
        end
    end

    fkr_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Advance count and scan index
    always_comb
    begin
        count_next = count_reg;
        if (cmd.count_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - CW'(1);
        end

        idx_next = idx_reg;
        if (cmd.rd_head)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = AW'(idx_ext + (CW + 1)'(1));
        end
    end

    // Build the result item
    always_comb
    begin
        result_next.ok          = cmd.ok;
        result_next.is_empty    = (count_next == '0);
        result_next.entry_total = TOTAL_W'(count_next);
        case (cmd.key_src)
            KSRC_RDATA: result_next.key_out = ram_rd_data;
            KSRC_HELD:  result_next.key_out = head_reg;
            default:    result_next.key_out = '0;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            done_reg  <= cmd.report;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= request.func;
            key_reg  <= request.client_key;
        end
        if (cmd.hold_head)
        begin
            head_reg <= ram_rd_data;
        end
        if (cmd.report)
        begin
            result_reg <= result_next;
        end
    end

    // Status back to the controller
    always_comb
    begin
        status.func      = func_reg;
        status.full      = (count_reg == CW'(DEPTH));
        status.empty     = (count_reg == '0);
        status.match     = (ram_rd_data == key_reg);
        status.has_next  = ((idx_ext + (CW + 1)'(1)) < count_ext);
        status.has_next2 = ((idx_ext + (CW + 1)'(2)) < count_ext);
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule : fkr_datapath

`default_nettype wire
